>>> hw/rtl/plug_control_register_file_top_defines.svh
// Assertion macros for the plug control register file.
// Used by plug_control_register_file_top; expects clk and rst in scope.
`ifndef PLUG_CONTROL_REGISTER_FILE_TOP_DEFINES_SVH
`define PLUG_CONTROL_REGISTER_FILE_TOP_DEFINES_SVH

// same-cycle implication
`define PCRF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pcrf_pkg.sv
// Shared types, codes and constants of the plug control register file.
// No dependencies; used by pcrf_word_store and plug_control_register_file_top.
`default_nettype none

package pcrf_pkg;

  localparam int WORDS         = 64;
  localparam int IDX_W         = 6;
  localparam int PLUGS_DEFAULT = 31;
  localparam int BLOCK_BYTES   = WORDS * 4;

  localparam logic [15:0] BASE_HIGH_RST = 16'hFFFF;
  localparam logic [31:0] BASE_LOW_RST  = 32'hF000_0900;
  localparam logic        NOTIFY_RST    = 1'b1;

  localparam logic [31:0] P2P_MASK       = 32'h3F00_0000;
  localparam logic [31:0] P2P_KEEP       = 32'hC0FF_FFFF;
  localparam logic [15:0] RESET_SOURCE   = 16'hFFFF;
  localparam logic [31:0] OUT_MASTER_RST = 32'hBF00_FF00;
  localparam logic [31:0] IN_MASTER_RST  = 32'h8000_FF00;
  localparam logic [IDX_W-1:0] OUT_MASTER_IDX = 6'd0;
  localparam logic [IDX_W-1:0] IN_MASTER_IDX  = 6'd32;

  localparam logic [1:0] CFG_BASE_HIGH = 2'd0;
  localparam logic [1:0] CFG_BASE_LOW  = 2'd1;
  localparam logic [1:0] CFG_NOTIFY    = 2'd2;

  typedef enum logic [2:0] {
    OP_BUS_WRITE = 3'd0,
    OP_READ      = 3'd1,
    OP_UPDATE    = 3'd2,
    OP_ALLOCATE  = 3'd3,
    OP_FREE      = 3'd4,
    OP_BUS_RESET = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_ADDR_ERR  = 3'd1,
    STATUS_TYPE_ERR  = 3'd2,
    STATUS_LOCK_FAIL = 3'd3,
    STATUS_NO_RES    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_ALLOC,
    S_SCAN,
    S_CLOSE
  } state_t;

  typedef struct packed {
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             wr;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             wr_client;
  } mem_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [4:0]  allocated_plug;
    logic        notify_client;
    logic        notify_target;
    logic        plug_kind;
    logic [4:0]  plug_number;
    logic [15:0] source_node;
    logic [31:0] previous_word;
    logic [31:0] current_word;
    logic        last;
  } result_t;

  function automatic logic [31:0] reset_word(input logic [IDX_W-1:0] a,
                                             input logic [4:0] plugs);
    logic [31:0] w;
    w = '0;
    if (a == OUT_MASTER_IDX) begin
      w = OUT_MASTER_RST | {27'd0, plugs};
    end else if (a == IN_MASTER_IDX) begin
      w = IN_MASTER_RST | {27'd0, plugs};
    end
    return w;
  endfunction

  function automatic logic is_target(input logic [IDX_W-1:0] a, input logic [4:0] plugs);
    return (a[4:0] != 5'd0) && (a[4:0] <= plugs);
  endfunction

  function automatic logic [4:0] plug_no(input logic [IDX_W-1:0] a);
    return a[4:0] - 5'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/plug_control_register_file_top.sv
// Plug control register file, top level: handshakes, config registers, sequencer.
// Depends on pcrf_pkg, pcrf_word_store and plug_control_register_file_top_defines.svh.
`default_nettype none
`include "plug_control_register_file_top_defines.svh"

// One item is taken at a time. Read, bus write, compare update, free and
// unknown ops read their word in the decode state and load the result in the
// exec state; allocate checks one client slot per cycle until it finds a free
// one or reaches the last plug; bus reset scans the plug words of both
// directions through the word RAM read port, one plug word per cycle unless a
// changed word waits for the result side. A finished result sits in an
// output register, so input is taken again as soon as the sequencer is idle.
// Reset contents are ready at once.
module plug_control_register_file_top #(
  parameter int PLUGS_PER_DIRECTION = pcrf_pkg::PLUGS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] address_high,
  input  wire logic [31:0] address_low,
  input  wire logic [15:0] length,
  input  wire logic        is_lock,
  input  wire logic [15:0] node_id,
  input  wire logic [5:0]  entry_index,
  input  wire logic        plug_direction,
  input  wire logic [31:0] old_value,
  input  wire logic [31:0] new_value,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       status,
  output logic [31:0]      read_value,
  output logic [4:0]       allocated_plug,
  output logic             notify_client,
  output logic             notify_target,
  output logic             plug_kind,
  output logic [4:0]       plug_number,
  output logic [15:0]      source_node,
  output logic [31:0]      previous_word,
  output logic [31:0]      current_word,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pcrf_pkg::*;

  localparam logic [4:0] PLUG_CNT  = 5'(PLUGS_PER_DIRECTION);
  localparam logic [4:0] PLUG_LAST = 5'(PLUGS_PER_DIRECTION - 1);

  state_t state, state_next;

  logic [15:0] base_high;
  logic [31:0] base_low;
  logic        notify_en;

  op_t              op_q;
  logic [15:0]      ahi_q;
  logic [31:0]      alo_q;
  logic [15:0]      len_q;
  logic             lock_q;
  logic [15:0]      node_q;
  logic [IDX_W-1:0] idx_q;
  logic             dir_q;
  logic [31:0]      oldv_q;
  logic [31:0]      newv_q;

  logic [IDX_W-1:0] acc_addr;
  status_t          wstat;
  logic             sc_dir;
  logic [4:0]       sc_num;
  logic [4:0]       al_num;

  result_t  res_q, res_next;
  mem_req_t mem_req;
  logic [31:0] rd_data;
  logic        rd_client;

  logic item_acc, out_free, load, scan_adv, al_adv;

  logic [32:0]      dec_sum, dec_lim;
  logic [7:0]       dec_off;
  logic             addr_ok, type_ok;
  status_t          dec_stat;
  logic [IDX_W-1:0] dec_addr;

  logic             sc_last;
  logic             nxt_dir;
  logic [4:0]       nxt_num;
  logic [IDX_W-1:0] sc_addr, al_addr;

  pcrf_word_store #(
    .PLUGS_PER_DIRECTION(PLUGS_PER_DIRECTION)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rd_data  (rd_data),
    .rd_client(rd_client)
  );

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_high <= BASE_HIGH_RST;
      base_low  <= BASE_LOW_RST;
      notify_en <= NOTIFY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_HIGH: base_high <= cfg_data[15:0];
        CFG_BASE_LOW:  base_low  <= cfg_data;
        CFG_NOTIFY:    notify_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      op_q   <= op_t'(op);
      ahi_q  <= address_high;
      alo_q  <= address_low;
      len_q  <= length;
      lock_q <= is_lock;
      node_q <= node_id;
      idx_q  <= entry_index;
      dir_q  <= plug_direction;
      oldv_q <= old_value;
      newv_q <= new_value;
    end
    if (state == S_DECODE) begin
      acc_addr <= dec_addr;
      wstat    <= dec_stat;
    end
    if (load) begin
      res_q <= res_next;
    end
  end

  // bus write address and type checks, and the word address of the item
  always_comb begin
    dec_sum  = {1'b0, alo_q} + 33'(len_q);
    dec_lim  = {1'b0, base_low} + 33'(BLOCK_BYTES);
    dec_off  = alo_q[7:0] - base_low[7:0];
    addr_ok  = (ahi_q == base_high) && (alo_q >= base_low) && (dec_sum <= dec_lim);
    type_ok  = lock_q && (len_q == 16'd4) && (alo_q[1:0] == 2'b00);
    dec_stat = !addr_ok ? STATUS_ADDR_ERR : (!type_ok ? STATUS_TYPE_ERR : STATUS_OK);
    dec_addr = (op_q == OP_BUS_WRITE) ? dec_off[7:2] : idx_q;
  end

  always_comb begin
    sc_last = (sc_num == PLUG_LAST);
    nxt_num = sc_last ? 5'd0 : sc_num + 5'd1;
    nxt_dir = sc_last ? 1'b1 : sc_dir;
    sc_addr = {sc_dir, sc_num + 5'd1};
    al_addr = {dir_q, al_num + 5'd1};
  end

  always_comb begin
    state_next = state;
    mem_req    = '0;
    res_next   = '0;
    load       = 1'b0;
    scan_adv   = 1'b0;
    al_adv     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_acc) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_q)
          OP_ALLOCATE: begin
            mem_req.rd      = 1'b1;
            mem_req.rd_addr = {dir_q, 5'd1};
            state_next      = S_ALLOC;
          end
          OP_BUS_RESET: begin
            mem_req.rd      = 1'b1;
            mem_req.rd_addr = {1'b0, 5'd1};
            state_next      = S_SCAN;
          end
          default: begin
            mem_req.rd      = 1'b1;
            mem_req.rd_addr = dec_addr;
            state_next      = S_EXEC;
          end
        endcase
      end
      S_EXEC: begin
        if (out_free) begin
          load          = 1'b1;
          state_next    = S_IDLE;
          res_next.last = 1'b1;
          unique case (op_q)
            OP_BUS_WRITE: begin
              res_next.status = wstat;
              if (wstat == STATUS_OK) begin
                mem_req.wr             = 1'b1;
                mem_req.wr_addr        = acc_addr;
                mem_req.wr_data        = newv_q;
                mem_req.wr_client      = rd_client;
                res_next.plug_kind     = acc_addr[5];
                res_next.plug_number   = plug_no(acc_addr);
                res_next.previous_word = rd_data;
                res_next.current_word  = newv_q;
                res_next.notify_client = rd_client;
                res_next.notify_target = notify_en && is_target(acc_addr, PLUG_CNT);
                res_next.source_node   = node_q;
              end
            end
            OP_READ: res_next.read_value = rd_data;
            OP_UPDATE: begin
              if (rd_data == oldv_q) begin
                mem_req.wr             = 1'b1;
                mem_req.wr_addr        = acc_addr;
                mem_req.wr_data        = newv_q;
                mem_req.wr_client      = rd_client;
                res_next.plug_kind     = acc_addr[5];
                res_next.plug_number   = plug_no(acc_addr);
                res_next.previous_word = oldv_q;
                res_next.current_word  = newv_q;
                res_next.notify_target = notify_en && is_target(acc_addr, PLUG_CNT);
              end else begin
                res_next.status = STATUS_LOCK_FAIL;
              end
            end
            OP_FREE: begin
              mem_req.wr             = 1'b1;
              mem_req.wr_addr        = acc_addr;
              mem_req.wr_data        = '0;
              mem_req.wr_client      = 1'b0;
              res_next.plug_kind     = acc_addr[5];
              res_next.plug_number   = plug_no(acc_addr);
              res_next.previous_word = rd_data;
            end
            default: res_next.status = STATUS_TYPE_ERR;
          endcase
        end
      end
      S_ALLOC: begin
        if (!rd_client) begin
          if (out_free) begin
            load                    = 1'b1;
            mem_req.wr              = 1'b1;
            mem_req.wr_addr         = al_addr;
            mem_req.wr_data         = rd_data;
            mem_req.wr_client       = 1'b1;
            res_next.allocated_plug = al_num;
            res_next.last           = 1'b1;
            state_next              = S_IDLE;
          end
        end else if (al_num == PLUG_LAST) begin
          if (out_free) begin
            load            = 1'b1;
            res_next.status = STATUS_NO_RES;
            res_next.last   = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          al_adv          = 1'b1;
          mem_req.rd      = 1'b1;
          mem_req.rd_addr = {dir_q, al_num + 5'd2};
        end
      end
      S_SCAN: begin
        if (((rd_data & P2P_MASK) == '0) || out_free) begin
          if ((rd_data & P2P_MASK) != '0) begin
            load                   = 1'b1;
            mem_req.wr             = 1'b1;
            mem_req.wr_addr        = sc_addr;
            mem_req.wr_data        = rd_data & P2P_KEEP;
            mem_req.wr_client      = rd_client;
            res_next.plug_kind     = sc_dir;
            res_next.plug_number   = sc_num;
            res_next.previous_word = rd_data;
            res_next.current_word  = rd_data & P2P_KEEP;
            res_next.notify_client = rd_client;
            res_next.notify_target = notify_en;
            res_next.source_node   = RESET_SOURCE;
          end
          if (sc_last && sc_dir) begin
            state_next = S_CLOSE;
          end else begin
            scan_adv        = 1'b1;
            mem_req.rd      = 1'b1;
            mem_req.rd_addr = {nxt_dir, nxt_num + 5'd1};
          end
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      sc_dir       <= 1'b0;
      sc_num       <= '0;
      al_num       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == S_DECODE) begin
        sc_dir <= 1'b0;
        sc_num <= '0;
        al_num <= '0;
      end else begin
        if (scan_adv) begin
          sc_dir <= nxt_dir;
          sc_num <= nxt_num;
        end
        if (al_adv) begin
          al_num <= al_num + 5'd1;
        end
      end
    end
  end

  assign status         = res_q.status;
  assign read_value     = res_q.read_value;
  assign allocated_plug = res_q.allocated_plug;
  assign notify_client  = res_q.notify_client;
  assign notify_target  = res_q.notify_target;
  assign plug_kind      = res_q.plug_kind;
  assign plug_number    = res_q.plug_number;
  assign source_node    = res_q.source_node;
  assign previous_word  = res_q.previous_word;
  assign current_word   = res_q.current_word;
  assign last           = res_q.last;

  `PCRF_ASSERT_IMPLIES(a_rw_distinct, mem_req.rd && mem_req.wr, mem_req.rd_addr != mem_req.wr_addr, "RAM read and write hit the same word")
  `PCRF_ASSERT_IMPLIES(a_scan_range, state == S_SCAN, sc_num <= PLUG_LAST, "scan pointer beyond last plug")
  `PCRF_ASSERT_IMPLIES(a_partial_only_reset, result_valid && !res_q.last, op_q == OP_BUS_RESET, "non-final result outside bus reset")
  `PCRF_ASSERT_NEXT(a_last_ends_item, load && res_next.last, state == S_IDLE, "final result did not end the item")

endmodule

`default_nettype wire

>>> hw/rtl/pcrf_word_store.sv
// Plug word store: 64 x 33 synchronous RAM (word and client-registered bit),
// with a registered read. Per-word valid bits stand in for the reset contents.
// Depends on pcrf_pkg.
`default_nettype none

module pcrf_word_store #(
  parameter int PLUGS_PER_DIRECTION = pcrf_pkg::PLUGS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pcrf_pkg::mem_req_t req,
  output logic [31:0]             rd_data,
  output logic                    rd_client
);
  import pcrf_pkg::*;

  localparam logic [4:0] PLUG_CNT = 5'(PLUGS_PER_DIRECTION);

  logic [32:0]      mem [WORDS];
  logic [WORDS-1:0] word_valid;
  logic [32:0]      rd_q;
  logic [31:0]      rd_dflt;
  logic             rd_use_dflt;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.wr_addr] <= {req.wr_client, req.wr_data};
    end
    if (req.rd) begin
      rd_q        <= mem[req.rd_addr];
      rd_dflt     <= reset_word(req.rd_addr, PLUG_CNT);
      rd_use_dflt <= !word_valid[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (req.wr) begin
      word_valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data   = rd_use_dflt ? rd_dflt : rd_q[31:0];
  assign rd_client = rd_use_dflt ? 1'b0 : rd_q[32];

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for plug_control_register_file_top: directed table, then random phases.
// Depends on pcrf_pkg; holds its own predictor of the plug words, client slots and settings.
`default_nettype none

module tb_top;
  import pcrf_pkg::*;

  localparam int PLUGS     = 31;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 75;
  localparam int HOLD_LEN  = 400;
  localparam int LIMIT     = 3000000;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ahi;
    logic [31:0] alo;
    logic [15:0] len;
    logic        lock;
    logic [15:0] node;
    logic [5:0]  idx;
    logic        dir;
    logic [31:0] oldv;
    logic [31:0] newv;
  } plug_req_t;

  typedef struct {
    plug_req_t   req;
    bit          fixed;
    status_t     st;
    logic [31:0] rv;
    logic [4:0]  ap;
  } plug_row_t;

  logic clk = 1'b0;
  logic rst;
  logic item_valid, item_stall;
  logic [2:0] op;
  logic [15:0] address_high;
  logic [31:0] address_low;
  logic [15:0] length;
  logic is_lock;
  logic [15:0] node_id;
  logic [5:0] entry_index;
  logic plug_direction;
  logic [31:0] old_value, new_value;
  logic result_valid, result_stall;
  logic [2:0] status;
  logic [31:0] read_value;
  logic [4:0] allocated_plug;
  logic notify_client, notify_target, plug_kind;
  logic [4:0] plug_number;
  logic [15:0] source_node;
  logic [31:0] previous_word, current_word;
  logic last;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  // predictor state
  logic [31:0] pcr_word [64];
  logic        pcr_client [64];
  logic [15:0] base_hi;
  logic [31:0] base_lo;
  logic        notify_en;

  result_t   expected_results [$];
  plug_row_t script [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_request = 1'b0;
  bit        hold_served = 1'b0;
  int        hold_cycles;
  result_t   seen_want;

  plug_control_register_file_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .address_high(address_high), .address_low(address_low), .length(length),
    .is_lock(is_lock), .node_id(node_id), .entry_index(entry_index),
    .plug_direction(plug_direction), .old_value(old_value), .new_value(new_value),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .read_value(read_value), .allocated_plug(allocated_plug),
    .notify_client(notify_client), .notify_target(notify_target), .plug_kind(plug_kind),
    .plug_number(plug_number), .source_node(source_node), .previous_word(previous_word),
    .current_word(current_word), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic result_t blank_result();
    result_t r;
    r = '0;
    r.status = STATUS_OK;
    return r;
  endfunction

  function automatic result_t fixed_result(input status_t st, input logic [31:0] rv,
                                           input logic [4:0] ap);
    result_t r;
    r = blank_result();
    r.status = st;
    r.read_value = rv;
    r.allocated_plug = ap;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic plug_is_reported(input logic [5:0] w);
    return (w[4:0] != 5'd0) && (int'(w[4:0]) <= PLUGS);
  endfunction

  function automatic result_t with_change(input result_t r, input logic [5:0] w,
                                          input logic [31:0] prev, input logic [31:0] cur);
    result_t c;
    c = r;
    c.plug_kind = w[5];
    c.plug_number = w[4:0] - 5'd1;
    c.previous_word = prev;
    c.current_word = cur;
    return c;
  endfunction

  task automatic reset_predictor();
    for (int k = 0; k < 64; k++) begin
      pcr_word[k] = 32'd0;
      pcr_client[k] = 1'b0;
    end
    pcr_word[0] = OUT_MASTER_RST | 32'(PLUGS);
    pcr_word[32] = IN_MASTER_RST | 32'(PLUGS);
    base_hi = BASE_HIGH_RST;
    base_lo = BASE_LOW_RST;
    notify_en = NOTIFY_RST;
  endtask

  task automatic predict_req(input plug_req_t q);
    result_t r, c;
    logic [33:0] top, lim;
    logic [31:0] diff, prev;
    logic [5:0] w;
    int slot0;
    bit found;
    r = blank_result();
    case (q.op)
      OP_BUS_WRITE: begin
        top = {18'd0, q.alo} + {18'd0, q.len};
        lim = {2'd0, base_lo} + 34'(BLOCK_BYTES);
        if (q.ahi != base_hi || q.alo < base_lo || top > lim) begin
          r.status = STATUS_ADDR_ERR;
        end else if (!q.lock || q.len != 16'd4 || q.alo[1:0] != 2'b00) begin
          r.status = STATUS_TYPE_ERR;
        end else begin
          diff = q.alo - base_lo;
          w = diff[7:2];
          prev = pcr_word[w];
          pcr_word[w] = q.newv;
          r = with_change(r, w, prev, q.newv);
          r.notify_client = pcr_client[w];
          r.notify_target = notify_en && plug_is_reported(w);
          r.source_node = q.node;
        end
      end
      OP_READ: r.read_value = pcr_word[q.idx];
      OP_UPDATE: begin
        if (pcr_word[q.idx] == q.oldv) begin
          pcr_word[q.idx] = q.newv;
          r = with_change(r, q.idx, q.oldv, q.newv);
          r.notify_target = notify_en && plug_is_reported(q.idx);
        end else begin
          r.status = STATUS_LOCK_FAIL;
        end
      end
      OP_ALLOCATE: begin
        slot0 = q.dir ? 33 : 1;
        found = 1'b0;
        r.status = STATUS_NO_RES;
        for (int i = 0; i < PLUGS; i++) begin
          if (!found && !pcr_client[slot0 + i]) begin
            found = 1'b1;
            pcr_client[slot0 + i] = 1'b1;
            r.status = STATUS_OK;
            r.allocated_plug = 5'(i);
          end
        end
      end
      OP_FREE: begin
        prev = pcr_word[q.idx];
        pcr_client[q.idx] = 1'b0;
        pcr_word[q.idx] = 32'd0;
        r = with_change(r, q.idx, prev, 32'd0);
      end
      OP_BUS_RESET: begin
        for (int d = 0; d < 2; d++) begin
          for (int i = 0; i < PLUGS; i++) begin
            w = 6'(d * 32 + 1 + i);
            prev = pcr_word[w];
            if ((prev & P2P_MASK) != 32'd0) begin
              pcr_word[w] = prev & P2P_KEEP;
              c = with_change(blank_result(), w, prev, pcr_word[w]);
              c.notify_client = pcr_client[w];
              c.notify_target = notify_en;
              c.source_node = RESET_SOURCE;
              expected_results.push_back(c);
            end
          end
        end
      end
      default: r.status = STATUS_TYPE_ERR;
    endcase
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  function automatic plug_req_t mk_req(input logic [2:0] o, input logic [15:0] ahi,
                                       input logic [31:0] alo, input logic [15:0] len,
                                       input logic lock, input logic [15:0] node,
                                       input logic [5:0] idx, input logic dir,
                                       input logic [31:0] oldv, input logic [31:0] newv);
    plug_req_t q;
    q.op = o; q.ahi = ahi; q.alo = alo; q.len = len; q.lock = lock; q.node = node;
    q.idx = idx; q.dir = dir; q.oldv = oldv; q.newv = newv;
    return q;
  endfunction

  function automatic plug_req_t random_req(input int alloc_pct);
    plug_req_t q;
    int pick;
    logic [31:0] start;
    q = mk_req(3'($urandom), 16'($urandom), $urandom, 16'($urandom), 1'($urandom),
               16'($urandom), 6'($urandom), 1'($urandom), $urandom, $urandom);
    if ($urandom_range(3) == 0) q.newv = q.newv & P2P_KEEP;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      q.op = OP_ALLOCATE;
      if (alloc_pct > 50) q.dir = ($urandom_range(4) == 0);
      return q;
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      q.op = OP_BUS_WRITE;
      start = (base_lo + 32'd3) & ~32'd3;
      if ($urandom_range(99) < 80) begin
        q.alo = start + 32'($urandom_range(63)) * 32'd4;
        q.ahi = base_hi; q.len = 16'd4; q.lock = 1'b1;
      end else begin
        q.alo = start + 32'($urandom_range(63)) * 32'd4;
        q.ahi = base_hi; q.len = 16'd4; q.lock = 1'b1;
        case ($urandom_range(4))
          0: q.ahi = 16'($urandom);
          1: q.alo = q.alo + 32'($urandom_range(3));
          2: q.len = 16'($urandom_range(12));
          3: q.lock = 1'b0;
          default: q.alo = $urandom;
        endcase
      end
    end else if (pick < 56) begin
      q.op = OP_READ;
    end else if (pick < 74) begin
      q.op = OP_UPDATE;
      if ($urandom_range(99) < 60) q.oldv = pcr_word[q.idx];
    end else if (pick < 86) begin
      q.op = OP_FREE;
    end else if (pick < 96) begin
      q.op = OP_BUS_RESET;
    end else begin
      q.op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    return q;
  endfunction

  task automatic add_row(input plug_req_t q, input bit fixed, input status_t st,
                         input logic [31:0] rv, input logic [4:0] ap);
    plug_row_t row;
    row.req = q; row.fixed = fixed; row.st = st; row.rv = rv; row.ap = ap;
    script.push_back(row);
  endtask

  task automatic send_req(input plug_req_t q, input bit fixed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    op <= q.op; address_high <= q.ahi; address_low <= q.alo; length <= q.len;
    is_lock <= q.lock; node_id <= q.node; entry_index <= q.idx;
    plug_direction <= q.dir; old_value <= q.oldv; new_value <= q.newv;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_req(q);
    if (fixed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_HIGH: base_hi = data[15:0];
      CFG_BASE_LOW:  base_lo = data;
      CFG_NOTIFY:    notify_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall, one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < HOLD_LEN) begin
          result_stall <= 1'b1;
          hold_cycles++;
          @(negedge clk);
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        seen_want = expected_results.pop_front();
        check_field("status", 32'(seen_want.status), 32'(status));
        check_field("read_value", seen_want.read_value, read_value);
        check_field("allocated_plug", 32'(seen_want.allocated_plug), 32'(allocated_plug));
        check_field("notify_client", 32'(seen_want.notify_client), 32'(notify_client));
        check_field("notify_target", 32'(seen_want.notify_target), 32'(notify_target));
        check_field("plug_kind", 32'(seen_want.plug_kind), 32'(plug_kind));
        check_field("plug_number", 32'(seen_want.plug_number), 32'(plug_number));
        check_field("source_node", 32'(seen_want.source_node), 32'(source_node));
        check_field("previous_word", seen_want.previous_word, previous_word);
        check_field("current_word", seen_want.current_word, current_word);
        check_field("last", 32'(seen_want.last), 32'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("plug_control_register_file_top test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    op = OP_READ; address_high = '0; address_low = '0; length = '0; is_lock = 1'b0;
    node_id = '0; entry_index = '0; plug_direction = 1'b0; old_value = '0; new_value = '0;
    cfg_valid = 1'b0; cfg_index = CFG_BASE_HIGH; cfg_data = '0;
    reset_predictor();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_stall_pct = 86;
    add_row(mk_req(OP_READ, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b0, 32'h0, 32'h0),
            1'b1, STATUS_OK, 32'hBF00_FF1F, 5'd0);
    add_row(mk_req(OP_READ, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd32, 1'b0, 32'h0, 32'h0),
            1'b1, STATUS_OK, 32'h8000_FF1F, 5'd0);
    add_row(mk_req(OP_READ, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd63, 1'b0, 32'h0, 32'h0),
            1'b1, STATUS_OK, 32'h0, 5'd0);
    // wrong upper address
    add_row(mk_req(OP_BUS_WRITE, 16'h0, 32'hF000_0904, 16'd4, 1'b1, 16'h1, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_ADDR_ERR, 32'h0, 5'd0);
    // not a lock, wrong length, misaligned
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0904, 16'd4, 1'b0, 16'h1, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_TYPE_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0904, 16'd8, 1'b1, 16'h1, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_TYPE_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0902, 16'd4, 1'b1, 16'h1, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_TYPE_ERR, 32'h0, 5'd0);
    // last word of the block, then one byte past it, then just below the base
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_09FC, 16'd4, 1'b1, 16'hFFFF, 6'd0, 1'b0,
                   32'h0, 32'hFFFF_FFFF), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_09FD, 16'd4, 1'b1, 16'h2, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_ADDR_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_08FC, 16'd4, 1'b1, 16'h2, 6'd0, 1'b0,
                   32'h0, 32'h1), 1'b1, STATUS_ADDR_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0904, 16'd4, 1'b1, 16'h1234, 6'd0, 1'b0,
                   32'h0, 32'h3F00_0001), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0900, 16'd4, 1'b1, 16'h0, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b0, STATUS_OK, 32'h0, 5'd0);
    // compare update: mismatch, then matches on a plug and on the top plug number
    add_row(mk_req(OP_UPDATE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd5, 1'b0,
                   32'h1, 32'h2), 1'b1, STATUS_LOCK_FAIL, 32'h0, 5'd0);
    add_row(mk_req(OP_UPDATE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd5, 1'b0,
                   32'h0, 32'h0100_0000), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_UPDATE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd31, 1'b0,
                   32'h0, 32'h3F00_0000), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_ALLOCATE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b1, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_ALLOCATE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b1,
                   32'h0, 32'h0), 1'b1, STATUS_OK, 32'h0, 5'd0);
    // write to a word with a registered client
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hF000_0904, 16'd4, 1'b1, 16'h00AA, 6'd0, 1'b0,
                   32'h0, 32'h2A00_0007), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_RESET, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_FREE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd1, 1'b0,
                   32'h0, 32'h0), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_FREE, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd32, 1'b0,
                   32'h0, 32'h0), 1'b0, STATUS_OK, 32'h0, 5'd0);
    add_row(mk_req(OP_SPARE_LO, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b1, STATUS_TYPE_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 6'd63, 1'b1,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, STATUS_TYPE_ERR, 32'h0, 5'd0);
    // end of range computed without wrap-around
    add_row(mk_req(OP_BUS_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b1, STATUS_ADDR_ERR, 32'h0, 5'd0);
    add_row(mk_req(OP_BUS_RESET, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 6'd0, 1'b0,
                   32'h0, 32'h0), 1'b0, STATUS_OK, 32'h0, 5'd0);
    foreach (script[k])
      send_req(script[k].req, script[k].fixed,
               fixed_result(script[k].st, script[k].rv, script[k].ap));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_cfg(CFG_BASE_HIGH, 32'h0000_FFFF);
          write_cfg(CFG_BASE_LOW, 32'hF000_0900);
          write_cfg(CFG_NOTIFY, 32'h1);
        end
        1: begin
          write_cfg(CFG_BASE_HIGH, 32'hFFFF_0000);
          write_cfg(CFG_BASE_LOW, 32'h0);
          write_cfg(CFG_NOTIFY, 32'hFFFF_FFFE);
        end
        2: begin
          write_cfg(CFG_BASE_HIGH, 32'hFFFF);
          write_cfg(CFG_BASE_LOW, 32'hFFFF_FF00);
          write_cfg(CFG_NOTIFY, 32'h1);
        end
        3: begin
          write_cfg(CFG_BASE_HIGH, $urandom);
          write_cfg(CFG_BASE_LOW, $urandom);
          write_cfg(CFG_NOTIFY, $urandom);
          write_cfg(CFG_SPARE, $urandom);
        end
        4: begin
          write_cfg(CFG_BASE_HIGH, $urandom);
          write_cfg(CFG_BASE_LOW, 32'hFFFF_FF01);
          write_cfg(CFG_NOTIFY, 32'h0);
        end
        default: begin
          write_cfg(CFG_BASE_HIGH, 32'hFFFF);
          write_cfg(CFG_BASE_LOW, 32'hF000_0900);
          write_cfg(CFG_NOTIFY, 32'h1);
        end
      endcase
      case (phase % 3)
        0: begin send_idle_pct = 11; recv_stall_pct = 86; end
        1: begin send_idle_pct = 86; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++)
        send_req(random_req((phase == 4) ? 60 : 12), 1'b0, blank_result());
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("plug_control_register_file_top test passed");
    else
      $display("plug_control_register_file_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
